// ===== hw/rtl/cfia_pkg.sv =====
// Package: item types, opcodes and defaults for the constant-fold integer ALU.
package cfia_pkg;

  localparam int DataWidthDefault = 64;

  typedef enum logic [4:0] {
    OP_ADD  = 5'd0,
    OP_SUB  = 5'd1,
    OP_MUL  = 5'd2,
    OP_XOR  = 5'd3,
    OP_AND  = 5'd4,
    OP_OR   = 5'd5,
    OP_DIV  = 5'd6,
    OP_MOD  = 5'd7,
    OP_LAND = 5'd8,
    OP_LOR  = 5'd9,
    OP_TERN = 5'd10,
    OP_NEG  = 5'd11,
    OP_NOT  = 5'd12,
    OP_SHL  = 5'd13,
    OP_SAR  = 5'd14,
    OP_SHR  = 5'd15,
    OP_EQ   = 5'd16,
    OP_LT   = 5'd17,
    OP_GT   = 5'd18,
    OP_ULT  = 5'd19,
    OP_UGT  = 5'd20
  } op_t;

  typedef struct packed {
    logic [4:0]         operation;
    logic signed [63:0] operand_a;
    logic signed [63:0] operand_b;
    logic signed [63:0] operand_c;
  } in_item_t;

  typedef struct packed {
    logic signed [63:0] result;
    logic               divide_by_zero;
  } out_item_t;

endpackage

// ===== hw/rtl/cfia_alu.sv =====
// Combinational simple operations and multiplier partial products.
module cfia_alu #(
  parameter int DATA_WIDTH = cfia_pkg::DataWidthDefault
) (
  input  logic [4:0]                    op,
  input  logic [DATA_WIDTH-1:0]         a,
  input  logic [DATA_WIDTH-1:0]         b,
  input  logic [DATA_WIDTH-1:0]         c,
  output logic [DATA_WIDTH-1:0]         sres,
  output logic [2*(DATA_WIDTH/2)-1:0]   pp0,
  output logic [DATA_WIDTH-1:0]         pp1,
  output logic [DATA_WIDTH-1:0]         pp2
);
  import cfia_pkg::*;

  localparam int W  = DATA_WIDTH;
  localparam int LO = W / 2;
  localparam int SW = $clog2(W);

  logic [SW-1:0] sh;
  logic          a_nz;

  assign sh   = SW'(b % W);
  assign a_nz = (a != '0);

  assign pp0 = (2*LO)'(a[LO-1:0]) * (2*LO)'(b[LO-1:0]);
  assign pp1 = W'(a[LO-1:0]) * W'(b[W-1:LO]);
  assign pp2 = W'(a[W-1:LO]) * W'(b[LO-1:0]);

  always_comb begin
    sres = '0;
    case (op)
      OP_ADD:  sres = a + b;
      OP_SUB:  sres = a - b;
      OP_XOR:  sres = a ^ b;
      OP_AND:  sres = a & b;
      OP_OR:   sres = a | b;
      OP_LAND: sres = a_nz ? b : '0;
      OP_LOR:  sres = a_nz ? a : b;
      OP_TERN: sres = a_nz ? b : c;
      OP_NEG:  sres = '0 - a;
      OP_NOT:  sres = ~a;
      OP_SHL:  sres = a << sh;
      OP_SAR:  sres = W'($signed(a) >>> sh);
      OP_SHR:  sres = a >> sh;
      OP_EQ:   sres = W'(a == b);
      OP_LT:   sres = W'($signed(a) < $signed(b));
      OP_GT:   sres = W'($signed(a) > $signed(b));
      OP_ULT:  sres = W'(a < b);
      OP_UGT:  sres = W'(a > b);
      default: sres = '0;
    endcase
  end

endmodule

// ===== hw/rtl/cfia_div_step.sv =====
// One restoring-division step: one quotient bit.
module cfia_div_step #(
  parameter int DATA_WIDTH = cfia_pkg::DataWidthDefault
) (
  input  logic [DATA_WIDTH-1:0] rem_i,
  input  logic [DATA_WIDTH-1:0] qd_i,
  input  logic [DATA_WIDTH-1:0] dvs_i,
  output logic [DATA_WIDTH-1:0] rem_o,
  output logic [DATA_WIDTH-1:0] qd_o
);
  import cfia_pkg::*;

  localparam int W = DATA_WIDTH;

  logic [W:0] trial;
  logic [W:0] diff;
  logic       ge;

  assign trial = {rem_i, qd_i[W-1]};
  assign diff  = trial - {1'b0, dvs_i};
  assign ge    = ~diff[W];
  assign rem_o = ge ? diff[W-1:0] : trial[W-1:0];
  assign qd_o  = {qd_i[W-2:0], ge};

endmodule

// ===== hw/rtl/constant_fold_integer_alu.sv =====
// Top level: pipelined constant-fold integer ALU.
// One item enters every cycle unless a stalled output holds the pipeline. Every
// operation travels through the division pipeline, one quotient bit per stage, so
// results keep their order. A stall while the output holds an item freezes the whole
// pipeline; no item is lost or repeated. Operands use their low DATA_WIDTH bits and the
// result is sign-extended to 64 bits. Division or mod by zero gives 0 with the flag set.
module constant_fold_integer_alu #(
  parameter int DATA_WIDTH = cfia_pkg::DataWidthDefault
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  cfia_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output cfia_pkg::out_item_t out_data
);
  import cfia_pkg::*;

  localparam int W  = DATA_WIDTH;
  localparam int LO = W / 2;

  logic adv;

  logic         va_r;
  logic [4:0]   opa_r;
  logic [W-1:0] aa_r, ba_r, ca_r;

  logic [W-1:0]      sres;
  logic [2*LO-1:0]   pp0;
  logic [W-1:0]      pp1, pp2;

  logic            vb_r;
  logic [4:0]      opb_r;
  logic [W-1:0]    sresb_r;
  logic [2*LO-1:0] pp0_r;
  logic [W-1:0]    pp1_r, pp2_r;
  logic [W-1:0]    qdb_r, dvsb_r;
  logic            negqb_r, negrb_r, dzb_r;

  logic [W-1:0] mul_res;

  logic         v_r     [W];
  logic [4:0]   op_r    [W];
  logic [W-1:0] res_r   [W];
  logic [W-1:0] rem_r   [W];
  logic [W-1:0] qd_r    [W];
  logic [W-1:0] dvs_r   [W];
  logic         negq_r  [W];
  logic         negr_r  [W];
  logic         dz_r    [W];
  logic [W-1:0] rem_nxt [W];
  logic [W-1:0] qd_nxt  [W];

  logic [W-1:0] fin;
  logic         fin_dz;
  logic         out_valid_r;
  out_item_t    out_r;

  assign adv      = ~out_valid_r | ~out_stall;
  assign in_stall = ~adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
    end else if (adv) begin
      va_r <= in_valid;
    end
    if (adv) begin
      opa_r <= in_data.operation;
      aa_r  <= in_data.operand_a[W-1:0];
      ba_r  <= in_data.operand_b[W-1:0];
      ca_r  <= in_data.operand_c[W-1:0];
    end
  end

  cfia_alu #(.DATA_WIDTH(W)) u_alu (
    .op(opa_r), .a(aa_r), .b(ba_r), .c(ca_r),
    .sres(sres), .pp0(pp0), .pp1(pp1), .pp2(pp2)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vb_r <= 1'b0;
    end else if (adv) begin
      vb_r <= va_r;
    end
    if (adv) begin
      opb_r   <= opa_r;
      sresb_r <= sres;
      pp0_r   <= pp0;
      pp1_r   <= pp1;
      pp2_r   <= pp2;
      qdb_r   <= aa_r[W-1] ? ('0 - aa_r) : aa_r;
      dvsb_r  <= ba_r[W-1] ? ('0 - ba_r) : ba_r;
      negqb_r <= aa_r[W-1] ^ ba_r[W-1];
      negrb_r <= aa_r[W-1];
      dzb_r   <= (ba_r == '0);
    end
  end

  assign mul_res = W'(pp0_r) + ((pp1_r + pp2_r) << LO);

  for (genvar k = 0; k < W; k++) begin : g_div
    if (k == 0) begin : g_first
      cfia_div_step #(.DATA_WIDTH(W)) u_step (
        .rem_i('0), .qd_i(qdb_r), .dvs_i(dvsb_r),
        .rem_o(rem_nxt[k]), .qd_o(qd_nxt[k])
      );
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          v_r[k] <= 1'b0;
        end else if (adv) begin
          v_r[k] <= vb_r;
        end
        if (adv) begin
          op_r[k]   <= opb_r;
          res_r[k]  <= (opb_r == OP_MUL) ? mul_res : sresb_r;
          rem_r[k]  <= rem_nxt[k];
          qd_r[k]   <= qd_nxt[k];
          dvs_r[k]  <= dvsb_r;
          negq_r[k] <= negqb_r;
          negr_r[k] <= negrb_r;
          dz_r[k]   <= dzb_r;
        end
      end
    end else begin : g_rest
      cfia_div_step #(.DATA_WIDTH(W)) u_step (
        .rem_i(rem_r[k-1]), .qd_i(qd_r[k-1]), .dvs_i(dvs_r[k-1]),
        .rem_o(rem_nxt[k]), .qd_o(qd_nxt[k])
      );
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          v_r[k] <= 1'b0;
        end else if (adv) begin
          v_r[k] <= v_r[k-1];
        end
        if (adv) begin
          op_r[k]   <= op_r[k-1];
          res_r[k]  <= res_r[k-1];
          rem_r[k]  <= rem_nxt[k];
          qd_r[k]   <= qd_nxt[k];
          dvs_r[k]  <= dvs_r[k-1];
          negq_r[k] <= negq_r[k-1];
          negr_r[k] <= negr_r[k-1];
          dz_r[k]   <= dz_r[k-1];
        end
      end
    end
  end

  always_comb begin
    fin    = res_r[W-1];
    fin_dz = 1'b0;
    case (op_r[W-1])
      OP_DIV: begin
        fin    = dz_r[W-1] ? '0 : (negq_r[W-1] ? ('0 - qd_r[W-1]) : qd_r[W-1]);
        fin_dz = dz_r[W-1];
      end
      OP_MOD: begin
        fin    = dz_r[W-1] ? '0 : (negr_r[W-1] ? ('0 - rem_r[W-1]) : rem_r[W-1]);
        fin_dz = dz_r[W-1];
      end
      default: begin
        fin    = res_r[W-1];
        fin_dz = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= v_r[W-1];
    end
    if (adv) begin
      out_r.result         <= 64'($signed(fin));
      out_r.divide_by_zero <= fin_dz;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.divide_by_zero |-> out_r.result == 64'd0)
    else $error("divide by zero with nonzero result");

  a_last_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    adv && v_r[W-1] |=> out_valid_r)
    else $error("item lost at output register");

  a_hold_last: assert property (@(posedge clk) disable iff (!rst_n)
    !adv && v_r[W-1] |=> v_r[W-1] && $stable(qd_r[W-1]))
    else $error("pipeline moved while stalled");

endmodule

// ===== tb/sv/tb_constant_fold_integer_alu.sv =====
// Testbench for the constant-fold integer ALU: directed and random items checked against a predictor.
`timescale 1ns / 100ps

module tb_constant_fold_integer_alu;
  import cfia_pkg::*;

  localparam int LATENCY     = 67;
  localparam int CYCLE_LIMIT = 200000;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;

  in_item_t  pending_items[$];
  out_item_t expected_results[$];
  int        mismatch_count;
  int        accepted_count;
  int        checked_count;
  int        cycle_count;
  int        burst_left;
  int        gap_left;
  int        stall_phase;
  bit        saw_div_zero;

  constant_fold_integer_alu DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  function automatic logic [63:0] trunc_quotient(logic [63:0] a, logic [63:0] b);
    logic [63:0] ma;
    logic [63:0] mb;
    logic [63:0] q;
    ma = a[63] ? -a : a;
    mb = b[63] ? -b : b;
    q  = ma / mb;
    return (a[63] != b[63]) ? -q : q;
  endfunction

  function automatic out_item_t fold_node(in_item_t item);
    out_item_t   r;
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] c;
    logic [5:0]  sh;
    a  = item.operand_a;
    b  = item.operand_b;
    c  = item.operand_c;
    sh = b[5:0];
    r.result         = '0;
    r.divide_by_zero = 1'b0;
    case (item.operation)
      OP_ADD:  r.result = a + b;
      OP_SUB:  r.result = a - b;
      OP_MUL:  r.result = a * b;
      OP_XOR:  r.result = a ^ b;
      OP_AND:  r.result = a & b;
      OP_OR:   r.result = a | b;
      OP_DIV: begin
        if (b == 0) r.divide_by_zero = 1'b1;
        else r.result = trunc_quotient(a, b);
      end
      OP_MOD: begin
        if (b == 0) r.divide_by_zero = 1'b1;
        else r.result = a - trunc_quotient(a, b) * b;
      end
      OP_LAND: r.result = (a != 0) ? b : 64'd0;
      OP_LOR:  r.result = (a != 0) ? a : b;
      OP_TERN: r.result = (a != 0) ? b : c;
      OP_NEG:  r.result = -a;
      OP_NOT:  r.result = ~a;
      OP_SHL:  r.result = a << sh;
      OP_SAR:  r.result = $signed(a) >>> sh;
      OP_SHR:  r.result = a >> sh;
      OP_EQ:   r.result = {63'd0, a == b};
      OP_LT:   r.result = {63'd0, $signed(a) < $signed(b)};
      OP_GT:   r.result = {63'd0, $signed(a) > $signed(b)};
      OP_ULT:  r.result = {63'd0, a < b};
      OP_UGT:  r.result = {63'd0, a > b};
      default: r.result = '0;
    endcase
    return r;
  endfunction

  function automatic logic [63:0] pick_operand();
    logic [63:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0: v = 64'h8000_0000_0000_0000;
      1: v = 64'h7FFF_FFFF_FFFF_FFFF;
      2: v = '1;
      3: v = '0;
      4: v = 64'($urandom_range(0, 70));
      5: v = -64'($urandom_range(1, 70));
      default: ;
    endcase
    return v;
  endfunction

  task automatic add_item(logic [4:0] op, logic [63:0] a, logic [63:0] b, logic [63:0] c);
    in_item_t item;
    item.operation = op;
    item.operand_a = a;
    item.operand_b = b;
    item.operand_c = c;
    pending_items.push_back(item);
  endtask

  initial begin
    logic [63:0] min_val;
    logic [63:0] max_val;
    min_val = 64'h8000_0000_0000_0000;
    max_val = 64'h7FFF_FFFF_FFFF_FFFF;
    for (int op = 0; op <= 20; op++) begin
      add_item(5'(op), 64'hFFFF_FFFF_FFFF_FFF9, 64'd3, 64'd55);
    end
    add_item(OP_DIV, 64'd17, 64'd0, 64'd0);
    add_item(OP_MOD, min_val, 64'd0, 64'd0);
    add_item(OP_DIV, min_val, '1, 64'd0);
    add_item(OP_MOD, min_val, '1, 64'd0);
    add_item(OP_SAR, min_val, 64'd63, 64'd0);
    add_item(OP_SHR, min_val, 64'd127, 64'd0);
    add_item(OP_SHL, max_val, 64'd64, 64'd0);
    add_item(OP_LAND, 64'd0, max_val, 64'd0);
    add_item(OP_LOR, 64'd0, min_val, 64'd0);
    add_item(OP_TERN, 64'd0, 64'd1, min_val);
    add_item(OP_LT, min_val, max_val, 64'd0);
    add_item(OP_UGT, min_val, max_val, 64'd0);
    add_item(5'd21, 64'd5, 64'd6, 64'd7);
    add_item(5'd31, '1, '1, '1);
    for (int i = 0; i < 1000; i++) begin
      add_item($urandom_range(0, 15) == 0 ? 5'($urandom_range(21, 31))
                                          : 5'($urandom_range(0, 20)),
               pick_operand(), pick_operand(), pick_operand());
    end
  end

  initial begin
    rst_n = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid    <= 1'b0;
      in_data     <= '0;
      burst_left  <= 0;
      gap_left    <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_results.push_back(fold_node(in_data));
        accepted_count = accepted_count + 1;
      end
      if (!in_valid || !in_stall) begin
        if (accepted_count == 500 && expected_results.size() != 0) begin
          in_valid <= 1'b0;
        end else if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (pending_items.size() != 0) begin
          in_valid <= 1'b1;
          in_data  <= pending_items.pop_front();
          if (burst_left > 1) begin
            burst_left <= burst_left - 1;
          end else begin
            burst_left <= $urandom_range(1, 40);
            gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      out_stall   <= 1'b0;
      stall_phase <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        checked_count = checked_count + 1;
        if (expected_results.size() == 0) begin
          mismatch_count = mismatch_count + 1;
          if (mismatch_count <= 10) $display("unexpected result %h", out_data);
        end else begin
          want = expected_results.pop_front();
          if (out_data.divide_by_zero) saw_div_zero = 1'b1;
          if (want.result !== out_data.result
              || want.divide_by_zero !== out_data.divide_by_zero) begin
            mismatch_count = mismatch_count + 1;
            if (mismatch_count <= 10) begin
              $display("mismatch: expected result %h dz %b, got result %h dz %b",
                       want.result, want.divide_by_zero,
                       out_data.result, out_data.divide_by_zero);
            end
          end
        end
      end
      stall_phase <= (stall_phase + 1) % 512;
      if (stall_phase < 128) out_stall <= 1'b0;
      else if (stall_phase < 256) out_stall <= ($urandom_range(0, 3) == 0);
      else out_stall <= ($urandom_range(0, 1) == 0);
    end
  end

  initial begin
    mismatch_count = 0;
    accepted_count = 0;
    checked_count  = 0;
    cycle_count    = 0;
    saw_div_zero   = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    wait (rst_n === 1'b1);
    wait (pending_items.size() == 0 && accepted_count > 0);
    @(posedge clk);
    while (in_valid || expected_results.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    if (expected_results.size() != 0) mismatch_count = mismatch_count + 1;
    $display("covered %0d items over all opcodes and unused codes, %0d results checked",
             accepted_count, checked_count);
    $display("divide by zero seen: %0d, mismatches: %0d", saw_div_zero, mismatch_count);
    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/cfia_pkg.sv
hw/rtl/cfia_alu.sv
hw/rtl/cfia_div_step.sv
hw/rtl/constant_fold_integer_alu.sv
tb/sv/tb_constant_fold_integer_alu.sv
